/* design/tlc_pkg.sv */
`default_nettype none
package tlc_pkg;

  // geometry
  localparam int ADDR_BITS = 48;
  localparam int LINE_BITS = 6;
  localparam int BLK_W     = ADDR_BITS - LINE_BITS;
  localparam int NEAR_SETS = 64;
  localparam int FAR_SETS  = 512;
  localparam int WAYS      = 8;
  localparam int WAY_IDX   = $clog2(WAYS);
  localparam int N_IDX     = $clog2(NEAR_SETS);
  localparam int F_IDX     = $clog2(FAR_SETS);
  localparam int N_TAG     = BLK_W - N_IDX;
  localparam int F_TAG     = BLK_W - F_IDX;
  localparam int CNT_W     = 48;
  localparam int STAT_N    = 7;
  localparam int OUT_W     = 2 + 2 + STAT_N * CNT_W;
  localparam int OUT_BYTES = (OUT_W + 7) / 8;

  localparam logic [63:0]      MAT_INIT = 64'h7F3F1F0F07030100;
  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};

  // result outcome codes
  localparam logic [1:0] OC_L1_HIT = 2'd0;
  localparam logic [1:0] OC_L2_HIT = 2'd1;
  localparam logic [1:0] OC_MISS   = 2'd2;

  // statistics counter slots
  typedef enum logic [2:0] {
    ST_RD  = 3'd0,
    ST_WR  = 3'd1,
    ST_L1H = 3'd2,
    ST_L1M = 3'd3,
    ST_L2H = 3'd4,
    ST_L2M = 3'd5,
    ST_WB  = 3'd6
  } stat_e;

  // per-set bookkeeping kept in one memory row
  typedef struct packed {
    logic [63:0]     rec;
    logic [WAYS-1:0] valid;
    logic [WAYS-1:0] dirty;
  } meta_t;

  typedef struct packed {
    logic               hit;
    logic [WAY_IDX-1:0] way;
  } way_hit_t;

  // controller to datapath
  typedef struct packed {
    logic             accept;
    logic             look;
    logic             vrd;
    logic             vlook;
    logic             finish;
    logic             clear;
    logic [F_IDX-1:0] clr_idx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic l1_hit;
    logic vic_dirty;
    logic out_free;
  } sts_t;

  // make way w most recent
  function automatic logic [63:0] mat_touch(input logic [63:0] m,
                                            input logic [WAY_IDX-1:0] w);
    logic [63:0] r;
    r = m;
    r[8*w +: 8] = {WAYS{1'b1}};
    for (int i = 0; i < WAYS; i++) begin
      r[8*i + int'(w)] = 1'b0;
    end
    return r;
  endfunction

  // lowest invalid way, else lowest way with an empty row
  function automatic logic [WAY_IDX-1:0] pick_victim(input logic [63:0] m,
                                                     input logic [WAYS-1:0] v);
    logic [WAY_IDX-1:0] p;
    p = '0;
    if (v != {WAYS{1'b1}}) begin
      for (int i = WAYS - 1; i >= 0; i--) begin
        if (!v[i]) p = WAY_IDX'(i);
      end
    end else begin
      for (int i = WAYS - 1; i >= 0; i--) begin
        if (m[8*i +: WAYS] == '0) p = WAY_IDX'(i);
      end
    end
    return p;
  endfunction

  // lowest set bit
  function automatic way_hit_t first_set(input logic [WAYS-1:0] vec);
    way_hit_t r;
    r = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        r.hit = 1'b1;
        r.way = WAY_IDX'(i);
      end
    end
    return r;
  endfunction

  // saturating add of 0..2
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] b,
                                               input logic [1:0] inc);
    logic [CNT_W:0] s;
    s = {1'b0, b} + {{(CNT_W-1){1'b0}}, inc};
    return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* design/tlc_ctrl.sv */
`default_nettype none
module tlc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire tlc_pkg::sts_t sts_i,
  output tlc_pkg::cmd_t      cmd_o
);
  import tlc_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_LOOK  = 6'b000100,
    S_VRD   = 6'b001000,
    S_VLOOK = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [F_IDX-1:0] clr_q, clr_d;

  // next state
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == F_IDX'(FAR_SETS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) state_d = S_LOOK;
      end
      S_LOOK: begin
        if (sts_i.l1_hit || !sts_i.vic_dirty) state_d = S_FIN;
        else state_d = S_VRD;
      end
      S_VRD:   state_d = S_VLOOK;
      S_VLOOK: state_d = S_FIN;
      S_FIN: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    s_axis_tready  = (state_q == S_IDLE);
    cmd_o          = '0;
    cmd_o.accept   = s_axis_tready && s_axis_tvalid;
    cmd_o.look     = (state_q == S_LOOK);
    cmd_o.vrd      = (state_q == S_VRD);
    cmd_o.vlook    = (state_q == S_VLOOK);
    cmd_o.finish   = (state_q == S_FIN) && sts_i.out_free;
    cmd_o.clear    = (state_q == S_CLEAR);
    cmd_o.clr_idx  = clr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

endmodule
`default_nettype wire

/* design/tlc_dpath.sv */
`default_nettype none
module tlc_dpath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire tlc_pkg::cmd_t                    cmd_i,
  output tlc_pkg::sts_t                         sts_o,
  input  wire logic [tlc_pkg::ADDR_BITS-1:0]    in_addr_i,
  input  wire logic                             in_wr_i,
  input  wire logic                             in_start_i,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [tlc_pkg::OUT_BYTES*8-1:0]       m_axis_tdata
);
  import tlc_pkg::*;

  // storage
  meta_t                   nmeta_mem [NEAR_SETS];
  logic [WAYS*N_TAG-1:0]   ntag_mem  [NEAR_SETS];
  meta_t                   fmeta_mem [FAR_SETS];
  logic [WAYS*F_TAG-1:0]   ftag_mem  [FAR_SETS];

  meta_t                 nmeta_rd_q, fmeta_rd_q;
  logic [WAYS*N_TAG-1:0] ntag_rd_q;
  logic [WAYS*F_TAG-1:0] ftag_rd_q;

  logic [BLK_W-1:0]  blk_q;
  logic              wr_q, start_q;
  logic [1:0]        outcome_q, outcome_d;
  logic [1:0]        wb_q, wb_d;
  logic [F_IDX-1:0]  sv_q;
  logic [F_TAG-1:0]  tv_q;
  logic [CNT_W-1:0]  cnt_q [STAT_N];
  logic              out_vld_q;
  logic [OUT_BYTES*8-1:0] out_q;

  logic [N_IDX-1:0] s1;
  logic [N_TAG-1:0] t1;
  logic [F_IDX-1:0] s2;
  logic [F_TAG-1:0] t2;
  logic [BLK_W-1:0] in_blk;

  assign in_blk = in_addr_i[ADDR_BITS-1:LINE_BITS];
  assign s1 = blk_q[N_IDX-1:0];
  assign t1 = blk_q[BLK_W-1:N_IDX];
  assign s2 = blk_q[F_IDX-1:0];
  assign t2 = blk_q[BLK_W-1:F_IDX];

  // near lookup and victim
  logic [WAYS-1:0]    nmatch;
  way_hit_t           nh;
  logic [WAY_IDX-1:0] v1;
  logic               vdirty;
  logic [N_TAG-1:0]   vtag;
  logic [BLK_W-1:0]   vblk;
  meta_t              nmeta_wd;
  logic [WAYS*N_TAG-1:0] ntag_wd;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      nmatch[i] = nmeta_rd_q.valid[i] && (ntag_rd_q[i*N_TAG +: N_TAG] == t1);
    end
    nh     = first_set(nmatch);
    v1     = pick_victim(nmeta_rd_q.rec, nmeta_rd_q.valid);
    vdirty = nmeta_rd_q.valid[v1] && nmeta_rd_q.dirty[v1];
    vtag   = ntag_rd_q[v1*N_TAG +: N_TAG];
    vblk   = {vtag, s1};
    nmeta_wd = nmeta_rd_q;
    ntag_wd  = ntag_rd_q;
    if (nh.hit) begin
      nmeta_wd.rec = mat_touch(nmeta_rd_q.rec, nh.way);
      if (wr_q) nmeta_wd.dirty[nh.way] = 1'b1;
    end else begin
      ntag_wd[v1*N_TAG +: N_TAG] = t1;
      nmeta_wd.valid[v1] = 1'b1;
      nmeta_wd.dirty[v1] = wr_q;
      nmeta_wd.rec = mat_touch(nmeta_rd_q.rec, v1);
    end
  end

  // far lookup, touch, mark or install; shared by demand and victim passes
  logic [F_TAG-1:0]   fcmp;
  logic [WAYS-1:0]    fmatch;
  way_hit_t           fh;
  logic [WAY_IDX-1:0] fv;
  logic               fwb;
  meta_t              fmeta_wd;
  logic [WAYS*F_TAG-1:0] ftag_wd;

  always_comb begin
    fcmp = cmd_i.vlook ? tv_q : t2;
    for (int i = 0; i < WAYS; i++) begin
      fmatch[i] = fmeta_rd_q.valid[i] && (ftag_rd_q[i*F_TAG +: F_TAG] == fcmp);
    end
    fh  = first_set(fmatch);
    fv  = pick_victim(fmeta_rd_q.rec, fmeta_rd_q.valid);
    fwb = 1'b0;
    fmeta_wd = fmeta_rd_q;
    ftag_wd  = ftag_rd_q;
    if (fh.hit) begin
      if (cmd_i.vlook) fmeta_wd.dirty[fh.way] = 1'b1;
      else fmeta_wd.rec = mat_touch(fmeta_rd_q.rec, fh.way);
    end else begin
      fwb = fmeta_rd_q.valid[fv] && fmeta_rd_q.dirty[fv];
      ftag_wd[fv*F_TAG +: F_TAG] = fcmp;
      fmeta_wd.valid[fv] = 1'b1;
      fmeta_wd.dirty[fv] = cmd_i.vlook;
      fmeta_wd.rec = mat_touch(fmeta_rd_q.rec, fv);
    end
  end

  // near memories
  meta_t meta_init;
  assign meta_init = '{rec: MAT_INIT, valid: '0, dirty: '0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      nmeta_rd_q <= nmeta_mem[in_blk[N_IDX-1:0]];
      ntag_rd_q  <= ntag_mem[in_blk[N_IDX-1:0]];
    end
    if (cmd_i.clear) begin
      nmeta_mem[cmd_i.clr_idx[N_IDX-1:0]] <= meta_init;
    end else if (cmd_i.look) begin
      nmeta_mem[s1] <= nmeta_wd;
      if (!nh.hit) ntag_mem[s1] <= ntag_wd;
    end
  end

  // far memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      fmeta_rd_q <= fmeta_mem[in_blk[F_IDX-1:0]];
      ftag_rd_q  <= ftag_mem[in_blk[F_IDX-1:0]];
    end else if (cmd_i.vrd) begin
      fmeta_rd_q <= fmeta_mem[sv_q];
      ftag_rd_q  <= ftag_mem[sv_q];
    end
    if (cmd_i.clear) begin
      fmeta_mem[cmd_i.clr_idx] <= meta_init;
    end else if ((cmd_i.look && !nh.hit) || cmd_i.vlook) begin
      fmeta_mem[cmd_i.vlook ? sv_q : s2] <= fmeta_wd;
      ftag_mem[cmd_i.vlook ? sv_q : s2]  <= ftag_wd;
    end
  end

  // per-item registers
  always_comb begin
    outcome_d = outcome_q;
    wb_d      = wb_q;
    if (cmd_i.look) begin
      outcome_d = nh.hit ? OC_L1_HIT : (fh.hit ? OC_L2_HIT : OC_MISS);
      wb_d      = {1'b0, !nh.hit && fwb};
    end else if (cmd_i.vlook) begin
      wb_d      = wb_q + {1'b0, fwb};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      blk_q   <= in_blk;
      wr_q    <= in_wr_i;
      start_q <= in_start_i;
    end
    if (cmd_i.look) begin
      sv_q <= vblk[F_IDX-1:0];
      tv_q <= vblk[BLK_W-1:F_IDX];
    end
    outcome_q <= outcome_d;
    wb_q      <= wb_d;
  end

  // statistics
  logic [1:0]       inc [STAT_N];
  logic [CNT_W-1:0] cnt_d [STAT_N];

  always_comb begin
    inc[ST_RD]  = {1'b0, !wr_q};
    inc[ST_WR]  = {1'b0, wr_q};
    inc[ST_L1H] = {1'b0, outcome_q == OC_L1_HIT};
    inc[ST_L1M] = {1'b0, outcome_q != OC_L1_HIT};
    inc[ST_L2H] = {1'b0, outcome_q == OC_L2_HIT};
    inc[ST_L2M] = {1'b0, outcome_q == OC_MISS};
    inc[ST_WB]  = wb_q;
    for (int k = 0; k < STAT_N; k++) begin
      cnt_d[k] = sat_add(start_q ? '0 : cnt_q[k], inc[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STAT_N; k++) cnt_q[k] <= '0;
    end else if (cmd_i.finish) begin
      for (int k = 0; k < STAT_N; k++) cnt_q[k] <= cnt_d[k];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q <= (OUT_BYTES*8)'({cnt_d[ST_WB], cnt_d[ST_L2M], cnt_d[ST_L2H],
                               cnt_d[ST_L1M], cnt_d[ST_L1H], cnt_d[ST_WR],
                               cnt_d[ST_RD], wb_q, outcome_q});
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = out_q;
  assign sts_o.l1_hit    = nh.hit;
  assign sts_o.vic_dirty = vdirty;
  assign sts_o.out_free  = !out_vld_q || m_axis_tready;

endmodule
`default_nettype wire

/* design/two_level_cache_lru_model.sv */
// Two-level write-back cache model: 8-way 64-set L1 and 8-way 512-set L2 with
// 64-byte lines and matrix LRU, returning one result item per access with the
// outcome, the dirty L2 evictions it caused and seven saturating statistics.
// Set state sits in single-port row memories read a whole set at a time. An
// item on an L1 hit or a clean-victim miss passes the lookup and finish
// states; a dirty L1 victim, which needs a second L2 set read, adds a victim
// read and a victim lookup state. A new item is taken only once the last
// one has finished. A finished result waits in the output register; while it
// is not taken the block can still take and look up one more item but holds
// its result back and accepts no further item. After reset a clearing pass over
// the 512 L2 sets initializes the set state; no item is accepted until it ends.
`default_nettype none
module two_level_cache_lru_model (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // address
  input  wire logic [1:0]  s_axis_tuser,  // write flag, start of run
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // outcome, writebacks_now, read_count, write_count, l1_hit_count,
  // l1_miss_count, l2_hit_count, l2_miss_count, writeback_count, zero pad
  output logic [tlc_pkg::OUT_BYTES*8-1:0] m_axis_tdata
);
  import tlc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tlc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  tlc_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_addr_i     (s_axis_tdata),
    .in_wr_i       (s_axis_tuser[0]),
    .in_start_i    (s_axis_tuser[1]),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire

/* tb/tlc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module tlc_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_ready_i,
  input  wire logic [47:0]                     in_addr_i,
  input  wire logic [1:0]                      in_flags_i,
  input  wire logic                            out_valid_i,
  input  wire logic                            out_ready_i,
  input  wire logic [tlc_pkg::OUT_BYTES*8-1:0] out_data_i,
  output int                                   fail_count_o,
  output int                                   pending_o,
  output int                                   access_count_o,
  output int                                   wb_seen_o
);
  import tlc_pkg::*;

  typedef struct packed {
    logic [1:0]             outcome;
    logic [1:0]             wb_now;
    logic [STAT_N*CNT_W-1:0] stats;
  } access_result_t;

  // private copy of the cache state
  logic [N_TAG-1:0] l1_tag [NEAR_SETS][WAYS];
  logic [63:0]      l1_rec [NEAR_SETS];
  logic [WAYS-1:0]  l1_val [NEAR_SETS];
  logic [WAYS-1:0]  l1_drt [NEAR_SETS];
  logic [F_TAG-1:0] l2_tag [FAR_SETS][WAYS];
  logic [63:0]      l2_rec [FAR_SETS];
  logic [WAYS-1:0]  l2_val [FAR_SETS];
  logic [WAYS-1:0]  l2_drt [FAR_SETS];
  logic [CNT_W-1:0] stat   [STAT_N];

  access_result_t expected_q [$];

  // set the row, then clear the column, so the diagonal ends up clear
  function automatic logic [63:0] make_mru(logic [63:0] m, int w);
    m[8*w +: 8] = 8'hFF;
    for (int i = 0; i < 8; i++) m[8*i + w] = 1'b0;
    return m;
  endfunction

  function automatic int victim_way(logic [63:0] m, logic [WAYS-1:0] v);
    if (v != '1) begin
      for (int i = 0; i < WAYS; i++) if (!v[i]) return i;
    end
    for (int i = 0; i < WAYS; i++) if (m[8*i +: 8] == 8'h00) return i;
    return 0;
  endfunction

  function automatic void count(stat_e k);
    if (stat[k] != CNT_MAX) stat[k] = stat[k] + 1'b1;
  endfunction

  // install a line in L2 as mru, returns 1 on a dirty eviction
  function automatic int l2_fill(int s, logic [F_TAG-1:0] t, logic d);
    int v;
    int wb;
    v = victim_way(l2_rec[s], l2_val[s]);
    wb = (l2_val[s][v] && l2_drt[s][v]) ? 1 : 0;
    l2_tag[s][v] = t;
    l2_val[s][v] = 1'b1;
    l2_drt[s][v] = d;
    l2_rec[s] = make_mru(l2_rec[s], v);
    return wb;
  endfunction

  function automatic int l2_find(int s, logic [F_TAG-1:0] t);
    for (int i = 0; i < WAYS; i++) if (l2_val[s][i] && l2_tag[s][i] == t) return i;
    return -1;
  endfunction

  function automatic access_result_t cache_access(logic [47:0] addr, logic wr, logic sor);
    access_result_t r;
    logic [BLK_W-1:0] blk;
    logic [BLK_W-1:0] vblk;
    int s1;
    int s2;
    int sv;
    int w;
    int v1;
    int wb;
    wb = 0;
    if (sor) for (int k = 0; k < STAT_N; k++) stat[k] = '0;
    count(wr ? ST_WR : ST_RD);
    blk = addr[47:LINE_BITS];
    s1 = int'(blk[N_IDX-1:0]);
    w = -1;
    for (int i = WAYS - 1; i >= 0; i--)
      if (l1_val[s1][i] && l1_tag[s1][i] == blk[BLK_W-1:N_IDX]) w = i;
    if (w >= 0) begin
      count(ST_L1H);
      l1_rec[s1] = make_mru(l1_rec[s1], w);
      if (wr) l1_drt[s1][w] = 1'b1;
      r.outcome = OC_L1_HIT;
    end else begin
      count(ST_L1M);
      s2 = int'(blk[F_IDX-1:0]);
      w = l2_find(s2, blk[BLK_W-1:F_IDX]);
      if (w >= 0) begin
        count(ST_L2H);
        l2_rec[s2] = make_mru(l2_rec[s2], w);
        r.outcome = OC_L2_HIT;
      end else begin
        count(ST_L2M);
        wb += l2_fill(s2, blk[BLK_W-1:F_IDX], 1'b0);
        r.outcome = OC_MISS;
      end
      // dirty l1 victim goes back to l2
      v1 = victim_way(l1_rec[s1], l1_val[s1]);
      if (l1_val[s1][v1] && l1_drt[s1][v1]) begin
        vblk = {l1_tag[s1][v1], N_IDX'(s1)};
        sv = int'(vblk[F_IDX-1:0]);
        w = l2_find(sv, vblk[BLK_W-1:F_IDX]);
        if (w >= 0) l2_drt[sv][w] = 1'b1;
        else wb += l2_fill(sv, vblk[BLK_W-1:F_IDX], 1'b1);
      end
      l1_tag[s1][v1] = blk[BLK_W-1:N_IDX];
      l1_val[s1][v1] = 1'b1;
      l1_drt[s1][v1] = wr;
      l1_rec[s1] = make_mru(l1_rec[s1], v1);
    end
    for (int k = 0; k < wb; k++) count(ST_WB);
    r.wb_now = wb[1:0];
    for (int k = 0; k < STAT_N; k++) r.stats[k*CNT_W +: CNT_W] = stat[k];
    return r;
  endfunction

  initial begin
    for (int s = 0; s < NEAR_SETS; s++) begin
      l1_rec[s] = MAT_INIT; l1_val[s] = '0; l1_drt[s] = '0;
    end
    for (int s = 0; s < FAR_SETS; s++) begin
      l2_rec[s] = MAT_INIT; l2_val[s] = '0; l2_drt[s] = '0;
    end
    for (int k = 0; k < STAT_N; k++) stat[k] = '0;
    fail_count_o = 0;
    pending_o = 0;
    access_count_o = 0;
    wb_seen_o = 0;
  end

  // predict on input items, compare on output items
  always @(posedge clk_i) begin
    access_result_t exp_r;
    access_result_t got;
    int errs;
    errs = 0;
    if (rst_ni && in_valid_i && in_ready_i) begin
      expected_q.push_back(cache_access(in_addr_i, in_flags_i[0], in_flags_i[1]));
      access_count_o <= access_count_o + 1;
    end
    if (rst_ni && out_valid_i && out_ready_i) begin
      got = {out_data_i[1:0], out_data_i[3:2], out_data_i[OUT_W-1:4]};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result item %h", $time, out_data_i);
        errs++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.wb_now != 0) wb_seen_o <= wb_seen_o + 1;
        if (got.outcome !== exp_r.outcome) begin
          $display("%0t: outcome exp %0d got %0d", $time, exp_r.outcome, got.outcome);
          errs++;
        end
        if (got.wb_now !== exp_r.wb_now) begin
          $display("%0t: writebacks_now exp %0d got %0d", $time, exp_r.wb_now, got.wb_now);
          errs++;
        end
        for (int k = 0; k < STAT_N; k++)
          if (got.stats[k*CNT_W +: CNT_W] !== exp_r.stats[k*CNT_W +: CNT_W]) begin
            $display("%0t: counter %0d exp %0d got %0d", $time, k,
                     exp_r.stats[k*CNT_W +: CNT_W], got.stats[k*CNT_W +: CNT_W]);
            errs++;
          end
      end
    end
    fail_count_o <= fail_count_o + errs;
    pending_o <= expected_q.size();
  end

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import tlc_pkg::*;

  localparam int MAX_CYCLES = 400000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [47:0]            s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_BYTES*8-1:0] m_axis_tdata;

  int  fail_count;
  int  pending;
  int  access_count;
  int  wb_seen;
  int  cycle_count = 0;
  bit  calm = 1'b0;
  bit  hold_sink = 1'b0;

  two_level_cache_lru_model i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  tlc_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_i(s_axis_tready),
    .in_addr_i(s_axis_tdata), .in_flags_i(s_axis_tuser),
    .out_valid_i(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_i(m_axis_tdata),
    .fail_count_o(fail_count), .pending_o(pending),
    .access_count_o(access_count), .wb_seen_o(wb_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("FAIL two_level_cache_lru_model");
      $finish;
    end
  end

  // result side, random stalls or a long hold
  always @(posedge clk_i) begin
    if (hold_sink) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 35);
  end

  // hold the sink for a long stretch
  initial begin
    @(posedge clk_i iff access_count == 300);
    hold_sink = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_sink = 1'b0;
  end

  // send one item, with a random gap first outside the calm stretch
  task automatic send(input logic [47:0] addr, input logic wr, input logic sor);
    if (!calm) while ($urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= {sor, wr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // addresses that crowd a few sets so that evictions happen
  function automatic logic [47:0] crowded_addr();
    logic [47:0] a;
    a = 48'({$urandom, $urandom});
    a[14:6] = 9'($urandom_range(3)) * 9'd64 + 9'($urandom_range(1));
    a[47:15] = 33'($urandom_range(23));
    if ($urandom_range(9) == 0) a[47:15] = {$urandom, 1'b1};
    return a;
  endfunction

  initial begin
    logic [47:0] a;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, both kinds, set conflicts with dirty victims
    send(48'h0, 1'b0, 1'b1);
    send(48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);
    send(48'h0, 1'b1, 1'b0);
    send(48'h3F, 1'b0, 1'b0);
    send(48'hAAAA_AAAA_AAAA, 1'b1, 1'b0);
    send(48'h5555_5555_5555, 1'b0, 1'b0);
    for (int i = 1; i <= 10; i++) send(48'(i) << 15, 1'b1, 1'b0);
    for (int i = 1; i <= 4; i++) send(48'(i) << 12, 1'b0, 1'b0);
    send(48'h0, 1'b0, 1'b1);
    // pause until all results are back
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i iff pending == 0);
    // random part, with a calm stretch in the middle
    for (int n = 0; n < 1200; n++) begin
      calm = (n >= 500 && n < 650);
      a = ($urandom_range(4) == 0) ? 48'({$urandom, $urandom}) : crowded_addr();
      send(a, 1'($urandom), $urandom_range(99) == 0);
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i iff pending == 0);
    repeat (20) @(posedge clk_i);
    $display("covered %0d accesses, %0d of them causing dirty L2 evictions",
             access_count, wb_seen);
    if (fail_count == 0) $display("PASS two_level_cache_lru_model");
    else $display("FAIL two_level_cache_lru_model");
    $finish;
  end

endmodule
`default_nettype wire
